>>> rtl/core/tsfd_pkg.sv
// ----------------------------------------------------------------------------
// Time signal frame decoder package
// Shared types, timing windows and a BCD helper for the frame decoder.
// ----------------------------------------------------------------------------
package tsfd_pkg;

  // Pulse classification codes as they appear on the result channel.
  typedef enum logic [2:0] {
    EV_NONE    = 3'd0,
    EV_INVALID = 3'd1,
    EV_ZERO    = 3'd2,
    EV_ONE     = 3'd3,
    EV_SECOND  = 3'd4,
    EV_MINUTE  = 3'd5
  } pulse_e;

  // Timing windows in milliseconds.
  localparam int unsigned SECOND_MIN  = 900;
  localparam int unsigned SECOND_MAX  = 1100;
  localparam int unsigned MINUTE_MIN  = 1900;
  localparam int unsigned MINUTE_MAX  = 2100;
  localparam int unsigned ZERO_MIN    = 70;
  localparam int unsigned ZERO_MAX    = 130;
  localparam int unsigned ONE_MIN     = 170;
  localparam int unsigned ONE_MAX     = 230;
  localparam int unsigned RESET_AGE   = 1000;

  localparam int unsigned FRAME_LEN   = 59;
  localparam int unsigned CNT_W       = 6;
  localparam int unsigned YEAR_BASE   = 2000;

  localparam logic [7:0] BCD_WEIGHT [8] = '{8'd1, 8'd2, 8'd4, 8'd8,
                                            8'd10, 8'd20, 8'd40, 8'd80};

  typedef struct packed {
    logic        sync_error;
    logic        sync_ok;
    logic        clock_set;
    logic [6:0]  minute_value;
    logic [5:0]  hour_value;
    logic [5:0]  day_value;
    logic [2:0]  weekday_value;
    logic [4:0]  month_value;
    logic [11:0] year_value;
  } frame_status_t;

  typedef struct packed {
    pulse_e        pulse_event;
    logic          signal_lamp;
    frame_status_t status;
  } result_t;

  // Weighted BCD sum of up to eight bits, least significant first.
  function automatic logic [7:0] bcd_sum(input logic [7:0] b);
    logic [7:0] s;
    s = '0;
    for (int i = 0; i < 8; i++) begin
      if (b[i]) begin
        s = s + BCD_WEIGHT[i];
      end
    end
    return s;
  endfunction

endpackage

>>> rtl/core/time_signal_frame_decoder_top.sv
// ----------------------------------------------------------------------------
// Time signal frame decoder, top level
// A sample beat is held in the input register, then its result is written into the result queue and offered.
// Throughput: one sample per cycle while the result queue is not full.
// A two-entry result queue keeps samples flowing while a result waits.
// Reset is asynchronous and active low; the frame bit store is not cleared.
// ----------------------------------------------------------------------------
module time_signal_frame_decoder_top #(
  parameter int unsigned TIME_BITS = 16
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 in_valid_i,
  output logic                 in_ready_o,
  input  logic                 signal_level_i,
  input  logic [TIME_BITS-1:0] sample_time_i,
  output logic                 out_valid_o,
  input  logic                 out_ready_i,
  output logic [2:0]           pulse_event_o,
  output logic                 signal_lamp_o,
  output logic                 sync_error_o,
  output logic                 sync_ok_o,
  output logic                 clock_set_o,
  output logic [6:0]           minute_value_o,
  output logic [5:0]           hour_value_o,
  output logic [5:0]           day_value_o,
  output logic [2:0]           weekday_value_o,
  output logic [4:0]           month_value_o,
  output logic [11:0]          year_value_o
);
  import tsfd_pkg::*;

  logic                 s1_valid_q;
  logic                 s1_level_q;
  logic [TIME_BITS-1:0] s1_time_q;
  logic                 advance, buf_full;
  pulse_e               event_w;
  frame_status_t        status_w;
  result_t              res_in, res_out;

  assign advance    = s1_valid_q & ~buf_full;
  assign in_ready_o = ~s1_valid_q | advance;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else if (in_ready_o) begin
      s1_valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && in_ready_o) begin
      s1_level_q <= signal_level_i;
      s1_time_q  <= sample_time_i;
    end
  end

  tsfd_detect #(
    .TIME_BITS(TIME_BITS)
  ) u_detect (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .fire_i  (advance),
    .level_i (s1_level_q),
    .time_i  (s1_time_q),
    .event_o (event_w)
  );

  tsfd_frame u_frame (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .fire_i   (advance),
    .event_i  (event_w),
    .status_o (status_w)
  );

  always_comb begin
    res_in.pulse_event = event_w;
    res_in.signal_lamp = s1_level_q;
    res_in.status      = status_w;
  end

  tsfd_outbuf u_outbuf (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (advance),
    .data_i      (res_in),
    .full_o      (buf_full),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .data_o      (res_out)
  );

  assign pulse_event_o   = res_out.pulse_event;
  assign signal_lamp_o   = res_out.signal_lamp;
  assign sync_error_o    = res_out.status.sync_error;
  assign sync_ok_o       = res_out.status.sync_ok;
  assign clock_set_o     = res_out.status.clock_set;
  assign minute_value_o  = res_out.status.minute_value;
  assign hour_value_o    = res_out.status.hour_value;
  assign day_value_o     = res_out.status.day_value;
  assign weekday_value_o = res_out.status.weekday_value;
  assign month_value_o   = res_out.status.month_value;
  assign year_value_o    = res_out.status.year_value;

  // The clock is only loaded on a minute mark that closes a frame.
  a_strobe_on_minute: assert property (@(posedge clk_i) disable iff (!rst_ni)
    advance && status_w.clock_set |-> event_w == EV_MINUTE)
    else $error("clock strobe without a minute mark");

  // The two lamps are never lit together.
  a_lamps_exclusive: assert property (@(posedge clk_i) disable iff (!rst_ni)
    advance |-> !(status_w.sync_ok && status_w.sync_error))
    else $error("ok and error lamps both set");

  // A sample held back by a full queue stays in the input register.
  a_stage_holds: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s1_valid_q && !advance |=> s1_valid_q && $stable(s1_time_q) && $stable(s1_level_q))
    else $error("held sample lost or changed");

endmodule

>>> rtl/core/tsfd_detect.sv
// ----------------------------------------------------------------------------
// Pulse detector
// Classifies edges of the sampled signal by the time since the last fall, and flags a long stretch without one.
// ----------------------------------------------------------------------------
module tsfd_detect #(
  parameter int unsigned TIME_BITS = 16
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 fire_i,
  input  logic                 level_i,
  input  logic [TIME_BITS-1:0] time_i,
  output tsfd_pkg::pulse_e     event_o
);
  import tsfd_pkg::*;

  logic                 prev_level_q, prev_level_d;
  logic [TIME_BITS-1:0] last_fall_q, last_fall_d;
  logic [TIME_BITS-1:0] diff;
  logic signed [TIME_BITS-1:0] age;
  logic                 is_fall, is_rise;

  assign diff    = time_i - last_fall_q;
  assign age     = $signed(diff);
  assign is_fall = prev_level_q & ~level_i;
  assign is_rise = ~prev_level_q & level_i;

  always_comb begin
    event_o      = EV_NONE;
    prev_level_d = level_i;
    last_fall_d  = last_fall_q;
    if (is_fall) begin
      last_fall_d = time_i;
      if (age >= $signed(TIME_BITS'(SECOND_MIN)) && age <= $signed(TIME_BITS'(SECOND_MAX))) begin
        event_o = EV_SECOND;
      end else if (age >= $signed(TIME_BITS'(MINUTE_MIN)) &&
                   age <= $signed(TIME_BITS'(MINUTE_MAX))) begin
        event_o = EV_MINUTE;
      end else begin
        event_o = EV_INVALID;
      end
    end else if (is_rise) begin
      if (age >= $signed(TIME_BITS'(ZERO_MIN)) && age <= $signed(TIME_BITS'(ZERO_MAX))) begin
        event_o = EV_ZERO;
      end else if (age >= $signed(TIME_BITS'(ONE_MIN)) && age <= $signed(TIME_BITS'(ONE_MAX))) begin
        event_o = EV_ONE;
      end else begin
        event_o = EV_INVALID;
      end
    end else if (age > $signed(TIME_BITS'(MINUTE_MAX))) begin
      // A long stretch without an edge is reported on every sample.
      event_o = EV_INVALID;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      prev_level_q <= 1'b1;
      last_fall_q  <= '0 - TIME_BITS'(RESET_AGE);
    end else if (fire_i) begin
      prev_level_q <= prev_level_d;
      last_fall_q  <= last_fall_d;
    end
  end

endmodule

>>> rtl/core/tsfd_frame.sv
// ----------------------------------------------------------------------------
// Frame decoder
// Sync state machine, 59-bit indexed frame bit store and parity/BCD decode.
// ----------------------------------------------------------------------------
module tsfd_frame (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    fire_i,
  input  tsfd_pkg::pulse_e        event_i,
  output tsfd_pkg::frame_status_t status_o
);
  import tsfd_pkg::*;

  typedef enum logic [1:0] {
    PH_IDLE      = 2'd0,
    PH_WAIT_RISE = 2'd1,
    PH_WAIT_FALL = 2'd2
  } phase_e;

  phase_e              phase_q, phase_d;
  logic [CNT_W-1:0]    cnt_q, cnt_d;
  logic [FRAME_LEN-1:0] bits_q, bits_d;
  logic                err_q, err_d, ok_q, ok_d;
  logic [6:0]          min_q, min_d;
  logic [5:0]          hour_q, hour_d, day_q, day_d;
  logic [2:0]          wday_q, wday_d;
  logic [4:0]          mon_q, mon_d;
  logic [11:0]         year_q, year_d;
  logic                strobe, fault;
  logic [6:0]          dec_min;
  logic [5:0]          dec_hour, dec_day;
  logic [2:0]          dec_wday;
  logic [4:0]          dec_mon;
  logic [7:0]          dec_year;
  logic                frame_ok;

  assign dec_min  = 7'(bcd_sum({1'b0, bits_q[27:21]}));
  assign dec_hour = 6'(bcd_sum({2'b0, bits_q[34:29]}));
  assign dec_day  = 6'(bcd_sum({2'b0, bits_q[41:36]}));
  assign dec_wday = 3'(bcd_sum({5'b0, bits_q[44:42]}));
  assign dec_mon  = 5'(bcd_sum({3'b0, bits_q[49:45]}));
  assign dec_year = bcd_sum(bits_q[57:50]);

  // Start bit set and all three even parity groups clean.
  assign frame_ok = bits_q[20] & ~(^bits_q[28:21]) & ~(^bits_q[35:29]) &
                    ~(^bits_q[58:36]);

  always_comb begin
    phase_d = phase_q;
    cnt_d   = cnt_q;
    bits_d  = bits_q;
    err_d   = err_q;
    ok_d    = ok_q;
    min_d   = min_q;
    hour_d  = hour_q;
    day_d   = day_q;
    wday_d  = wday_q;
    mon_d   = mon_q;
    year_d  = year_q;
    strobe  = 1'b0;
    fault   = 1'b1;

    if (fire_i && event_i != EV_NONE) begin
      unique case (phase_q)
        PH_WAIT_RISE: begin
          if (event_i == EV_ZERO || event_i == EV_ONE) begin
            if (cnt_q < CNT_W'(FRAME_LEN)) begin
              bits_d[cnt_q] = (event_i == EV_ONE);
            end
            cnt_d   = cnt_q + CNT_W'(1);
            phase_d = PH_WAIT_FALL;
          end else begin
            phase_d = PH_IDLE;
            err_d   = 1'b1;
            ok_d    = 1'b0;
          end
        end
        PH_WAIT_FALL: begin
          if (event_i == EV_SECOND && cnt_q < CNT_W'(FRAME_LEN)) begin
            phase_d = PH_WAIT_RISE;
          end else if (event_i == EV_MINUTE && cnt_q == CNT_W'(FRAME_LEN)) begin
            // Fields are stored in order until the first range check fails.
            if (frame_ok) begin
              min_d = dec_min;
              if (dec_min <= 7'd59) begin
                hour_d = dec_hour;
                if (dec_hour <= 6'd23) begin
                  strobe = 1'b1;
                  day_d  = dec_day;
                  if (dec_day != '0 && dec_day <= 6'd31) begin
                    wday_d = dec_wday;
                    mon_d  = dec_mon;
                    if (dec_mon != '0 && dec_mon <= 5'd12) begin
                      year_d = 12'(YEAR_BASE) + 12'(dec_year);
                      fault  = 1'b0;
                    end
                  end
                end
              end
            end
            if (fault) begin
              phase_d = PH_IDLE;
              err_d   = 1'b1;
              ok_d    = 1'b0;
            end else begin
              cnt_d   = '0;
              phase_d = PH_WAIT_RISE;
              err_d   = 1'b0;
              ok_d    = 1'b1;
            end
          end else begin
            phase_d = PH_IDLE;
            err_d   = 1'b1;
            ok_d    = 1'b0;
          end
        end
        default: begin
          if (event_i == EV_MINUTE) begin
            cnt_d   = '0;
            phase_d = PH_WAIT_RISE;
          end
        end
      endcase
    end
  end

  always_comb begin
    status_o.sync_error    = err_d;
    status_o.sync_ok       = ok_d;
    status_o.clock_set     = strobe;
    status_o.minute_value  = min_d;
    status_o.hour_value    = hour_d;
    status_o.day_value     = day_d;
    status_o.weekday_value = wday_d;
    status_o.month_value   = mon_d;
    status_o.year_value    = year_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= PH_IDLE;
      cnt_q   <= '0;
      err_q   <= 1'b0;
      ok_q    <= 1'b0;
      min_q   <= '0;
      hour_q  <= '0;
      day_q   <= '0;
      wday_q  <= '0;
      mon_q   <= '0;
      year_q  <= '0;
    end else if (fire_i) begin
      phase_q <= phase_d;
      cnt_q   <= cnt_d;
      err_q   <= err_d;
      ok_q    <= ok_d;
      min_q   <= min_d;
      hour_q  <= hour_d;
      day_q   <= day_d;
      wday_q  <= wday_d;
      mon_q   <= mon_d;
      year_q  <= year_d;
    end
  end

  // Frame bits are only read after all 59 have been written since sync.
  always_ff @(posedge clk_i) begin
    if (fire_i) begin
      bits_q <= bits_d;
    end
  end

endmodule

>>> rtl/core/tsfd_outbuf.sv
// ----------------------------------------------------------------------------
// Result buffer
// Two-entry queue that parts the decoder from the result channel.
// ----------------------------------------------------------------------------
module tsfd_outbuf (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              push_i,
  input  tsfd_pkg::result_t data_i,
  output logic              full_o,
  output logic              out_valid_o,
  input  logic              out_ready_i,
  output tsfd_pkg::result_t data_o
);
  import tsfd_pkg::*;

  result_t    mem_q [2];
  logic       wr_ptr_q, rd_ptr_q;
  logic [1:0] count_q;
  logic       pop;

  assign out_valid_o = (count_q != 2'd0);
  assign full_o      = (count_q == 2'd2);
  assign pop         = out_valid_o & out_ready_i;
  assign data_o      = mem_q[rd_ptr_q];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      count_q  <= 2'd0;
    end else begin
      if (push_i) begin
        wr_ptr_q <= ~wr_ptr_q;
      end
      if (pop) begin
        rd_ptr_q <= ~rd_ptr_q;
      end
      if (push_i && !pop) begin
        count_q <= count_q + 2'd1;
      end else if (pop && !push_i) begin
        count_q <= count_q - 2'd1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= data_i;
    end
  end

endmodule
